// ===== rtl/dtsg_pkg.sv =====
// Shared constants, types and the quarter-wave sine table of the dual-tone generator.
package dtsg_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int PHASE_W = 32;
  localparam int IDX_W = SINE_TABLE_BITS;
  localparam int FRAC_W = IDX_W - 2;
  localparam int LUT_DEPTH = 1 << FRAC_W;
  localparam int X_SHIFT = 17 - SINE_TABLE_BITS;
  localparam int MAG_W = 15;
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W = 2;

  // Polynomial coefficients of the quarter-wave sine approximation.
  localparam longint POLY_A = 51472;
  localparam longint POLY_B = 21167;
  localparam longint POLY_C = 2463;

  // Largest sine magnitude; also the value at the quarter-turn points.
  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CARRIER_STEP  = 2'd0,
    CFG_LAYER_STEP    = 2'd1,
    CFG_CARRIER_LEVEL = 2'd2,
    CFG_LAYER_LEVEL   = 2'd3
  } cfg_reg_t;

  // One oscillator's sine as sign and magnitude.
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } sine_t;

  // Contents of the lookup stage register.
  typedef struct packed {
    sine_t carrier;
    sine_t layer;
    logic  muted;
    logic  block_end;
  } stage_t;

  typedef logic [MAG_W-1:0] sine_lut_t [LUT_DEPTH];

  // Builds the quarter-wave table at elaboration with the exact fixed-point polynomial.
  function automatic sine_lut_t build_sine_lut();
    sine_lut_t lut;
    longint    x;
    longint    x2;
    longint    t;
    longint    s;
    for (int i = 0; i < LUT_DEPTH; i++) begin
      x  = longint'(i) << X_SHIFT;
      x2 = (x * x) >> 15;
      t  = (POLY_C * x2) >> 15;
      t  = POLY_B - t;
      t  = (t * x2) >> 15;
      t  = POLY_A - t;
      s  = (x * t) >> 15;
      if (s > 32767) begin
        s = 32767;
      end
      lut[i] = MAG_W'(s);
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

// ===== rtl/dtsg_osc.sv =====
// Phase accumulator with quarter-wave sine lookup for one oscillator.
module dtsg_osc (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic [dtsg_pkg::PHASE_W-1:0] step,
  output dtsg_pkg::sine_t              sine
);

  logic [dtsg_pkg::PHASE_W-1:0] phase_r;
  logic [dtsg_pkg::PHASE_W-1:0] phase_nxt;
  logic [dtsg_pkg::IDX_W-1:0]   idx;
  logic [1:0]                   quad;
  logic [dtsg_pkg::FRAC_W-1:0]  frac;
  logic [dtsg_pkg::FRAC_W-1:0]  lut_addr;

  // The phase wraps modulo 2^32 and moves only for frames that are not muted.
  always_comb begin
    phase_nxt = advance ? phase_r + step : phase_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // Odd quadrants mirror the table; the mirrored zero offset is the quarter-turn peak.
  always_comb begin
    idx      = phase_r[dtsg_pkg::PHASE_W-1 -: dtsg_pkg::IDX_W];
    quad     = idx[dtsg_pkg::IDX_W-1 -: 2];
    frac     = idx[dtsg_pkg::FRAC_W-1:0];
    lut_addr = quad[0] ? -frac : frac;
    sine.neg = quad[1];
    if (quad[0] && (frac == '0)) begin
      sine.mag = dtsg_pkg::MAG_MAX;
    end else begin
      sine.mag = dtsg_pkg::SINE_LUT[lut_addr];
    end
  end

endmodule

// ===== rtl/dtsg_mix.sv =====
// Gain scaling of both oscillators, mixing and saturation to signed Q1.15.
module dtsg_mix (
  input  dtsg_pkg::stage_t                   item,
  input  logic [dtsg_pkg::GAIN_W-1:0]        carrier_level,
  input  logic [dtsg_pkg::GAIN_W-1:0]        layer_level,
  output logic signed [dtsg_pkg::SAMPLE_W-1:0] sample
);

  localparam int PROD_W = dtsg_pkg::MAG_W + dtsg_pkg::GAIN_W;
  localparam int TERM_W = PROD_W - 15;
  localparam int SUM_W = TERM_W + 2;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(32768);

  logic [PROD_W-1:0]       carrier_prod;
  logic [PROD_W-1:0]       layer_prod;
  logic signed [SUM_W-1:0] carrier_term;
  logic signed [SUM_W-1:0] layer_term;
  logic signed [SUM_W-1:0] sum;

  // Scale magnitudes, truncate, then restore the sign (truncation toward zero).
  always_comb begin
    carrier_prod = PROD_W'(item.carrier.mag) * PROD_W'(carrier_level);
    layer_prod   = PROD_W'(item.layer.mag) * PROD_W'(layer_level);
    carrier_term = $signed({2'b00, carrier_prod[PROD_W-1:15]});
    layer_term   = $signed({2'b00, layer_prod[PROD_W-1:15]});
    if (item.carrier.neg) begin
      carrier_term = -carrier_term;
    end
    if (item.layer.neg) begin
      layer_term = -layer_term;
    end
    sum = carrier_term + layer_term;
  end

  // Saturate the mix; a muted frame is silence.
  always_comb begin
    if (item.muted) begin
      sample = '0;
    end else if (sum > SAT_HI) begin
      sample = 16'sh7fff;
    end else if (sum < SAT_LO) begin
      sample = -16'sh8000;
    end else begin
      sample = sum[dtsg_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

// ===== rtl/dual_tone_sine_generator_core.sv =====
// Top level of the dual-tone sine generator: configuration, pipeline control and output.
//
// Each transfer on the input channel (in_valid/in_ready) requests one stereo frame;
// in_block_end is copied to out_frame_last. Each frame leaves on the output
// channel (out_valid/out_ready) with the same sample on left and right.
// The configuration port writes step and gain registers with cfg_wr_en,
// cfg_index and cfg_wr_data; write only while no frame is in flight.
// A frame accepted on the input channel is registered in the lookup stage,
// and the output register loads it from there once that register is free;
// the output register then offers the result on the output channel.
// Throughput: one frame per cycle while out_ready stays high. The phase
// update is one add per accumulator, the sine is a constant quarter-wave
// table read, and the output stage holds one multiply per oscillator plus
// the saturating add.
// Reset clears the phases, all configuration registers and both valid flags.
// When the receiver stalls, the output register holds its frame and the
// lookup stage still takes one more frame; after that in_ready drops
// until out_ready returns.
module dual_tone_sine_generator_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [dtsg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dtsg_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_block_end,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [dtsg_pkg::SAMPLE_W-1:0] out_left_sample,
  output logic signed [dtsg_pkg::SAMPLE_W-1:0] out_right_sample,
  output logic                                 out_frame_last
);

  logic [dtsg_pkg::PHASE_W-1:0]         carrier_step_r;
  logic [dtsg_pkg::PHASE_W-1:0]         layer_step_r;
  logic [dtsg_pkg::GAIN_W-1:0]          carrier_level_r;
  logic [dtsg_pkg::GAIN_W-1:0]          layer_level_r;
  dtsg_pkg::stage_t                     stage_r;
  dtsg_pkg::stage_t                     stage_nxt;
  logic                                 stage_valid_r;
  logic                                 out_valid_r;
  logic signed [dtsg_pkg::SAMPLE_W-1:0] sample_r;
  logic                                 frame_last_r;
  logic                                 out_free;
  logic                                 in_xfer;
  logic                                 muted;
  dtsg_pkg::sine_t                      carrier_sine;
  dtsg_pkg::sine_t                      layer_sine;
  logic signed [dtsg_pkg::SAMPLE_W-1:0] mix_sample;

  // Configuration register writes; indexes with no register are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_step_r  <= '0;
      layer_step_r    <= '0;
      carrier_level_r <= '0;
      layer_level_r   <= '0;
    end else if (cfg_wr_en) begin
      case (dtsg_pkg::cfg_reg_t'(cfg_index))
        dtsg_pkg::CFG_CARRIER_STEP:  carrier_step_r  <= cfg_wr_data;
        dtsg_pkg::CFG_LAYER_STEP:    layer_step_r    <= cfg_wr_data;
        dtsg_pkg::CFG_CARRIER_LEVEL: carrier_level_r <= cfg_wr_data[dtsg_pkg::GAIN_W-1:0];
        dtsg_pkg::CFG_LAYER_LEVEL:   layer_level_r   <= cfg_wr_data[dtsg_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: each stage moves when its successor is empty or moving.
  always_comb begin
    out_free = !out_valid_r || out_ready;
    in_ready = !stage_valid_r || out_free;
    in_xfer  = in_valid && in_ready;
    muted    = (carrier_level_r == '0);
  end

  dtsg_osc u_carrier (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_xfer && !muted),
    .step    (carrier_step_r),
    .sine    (carrier_sine)
  );

  dtsg_osc u_layer (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_xfer && !muted),
    .step    (layer_step_r),
    .sine    (layer_sine)
  );

  // Lookup stage contents for the frame being accepted.
  always_comb begin
    stage_nxt.carrier   = carrier_sine;
    stage_nxt.layer     = layer_sine;
    stage_nxt.muted     = muted;
    stage_nxt.block_end = in_block_end;
  end

  dtsg_mix u_mix (
    .item          (stage_r),
    .carrier_level (carrier_level_r),
    .layer_level   (layer_level_r),
    .sample        (mix_sample)
  );

  // Valid flags of the lookup stage and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_ready) begin
        stage_valid_r <= in_xfer;
      end
      if (out_free) begin
        out_valid_r <= stage_valid_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stage_r <= stage_nxt;
    end
    if (out_free && stage_valid_r) begin
      sample_r     <= mix_sample;
      frame_last_r <= stage_r.block_end;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left_sample  = sample_r;
  assign out_right_sample = sample_r;
  assign out_frame_last   = frame_last_r;

endmodule

// ===== rtl/dtsg_checker.sv =====
// Port-level checks for the dual-tone sine generator, bound to its top level.
module dtsg_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [dtsg_pkg::SAMPLE_W-1:0] out_left_sample,
  input logic signed [dtsg_pkg::SAMPLE_W-1:0] out_right_sample,
  input logic                                 out_frame_last
);

  // A stalled result keeps its valid and payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left_sample) &&
      $stable(out_frame_last))
    else $error("output transfer changed while stalled");

  // Both channels carry the same mixed sample.
  a_stereo_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_left_sample == out_right_sample)
    else $error("left and right samples differ");

  // The block refuses input only while a finished result is waiting.
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused with output free");

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind dual_tone_sine_generator_core dtsg_checker u_dtsg_checker (.*);
